// ===== hdl/sm3_pkg.sv =====
// Shared types, constants and round functions for the SM3 hash engine.
// Standalone package; used by sm3_msg_sched, sm3_round and sm3_hash_engine.
`default_nettype none

package sm3_pkg;

    typedef logic [7:0][31:0] sm3_words_t;

    localparam sm3_words_t SM3_IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    localparam logic [7:0]  SM3_PAD_BYTE = 8'h80;
    localparam logic [5:0]  SM3_LEN_POS  = 6'd56;
    localparam logic [5:0]  SM3_LAST_POS = 6'd63;
    localparam logic [5:0]  SM3_LAST_RND = 6'd63;
    localparam logic [31:0] SM3_T_LO     = 32'h79CC4519;
    localparam logic [31:0] SM3_T_HI     = 32'h7A879D8A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sm3_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sm3_out_t;

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic        wr_en;
        logic [5:0]  wr_addr;
        logic [7:0]  wr_data;
        logic        load;
        logic        mark;
        logic        len_en;
        logic [5:0]  pad_n;
        logic [63:0] length;
        logic        shift;
    } sm3_sched_ctrl_t;

    // Status from the round unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } sm3_rnd_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [5:0] rn;
        rn = 6'd32 - {1'b0, n};
        return (x << n) | (x >> rn);
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    // Round constant rotated by the round number
    function automatic logic [31:0] tj_rot(input logic [5:0] j);
        logic [31:0] t;
        t = (j < 6'd16) ? SM3_T_LO : SM3_T_HI;
        return rotl(t, j[4:0]);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sm3_hash_engine.sv =====
// SM3 hash engine top level: byte intake, padding sequencer, chaining value
// and digest output. Uses sm3_pkg, sm3_msg_sched and sm3_round.
// Intake: a byte that leaves the block open is written to the buffer and the engine
// stays ready; a byte that fills the block is followed by 64 rounds of the shared
// round unit, done and merge before the next byte is taken. End of message: the
// accepting step, that compression if its byte fills it, then one padded block (or
// two past 55 pending bytes), then 8 output beats. One item at a time.
// Reset: chaining value to the SM3 IV, bit count to zero; block buffer is not cleared.
`default_nettype none

module sm3_hash_engine (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sm3_pkg::sm3_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output sm3_pkg::sm3_out_t     out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMP = 3'd1;
    localparam logic [2:0] S_NEXT = 3'd2;
    localparam logic [2:0] S_PAD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                pend_end_reg, pend_end_next;
    logic                fin_reg, fin_next;
    logic                extra_reg, extra_next;
    logic [2:0]          word_idx_reg, word_idx_next;
    logic [63:0]         count_reg, count_next;
    sm3_pkg::sm3_words_t cv_reg, cv_next;

    sm3_pkg::sm3_sched_ctrl_t sctrl;
    sm3_pkg::sm3_rnd_stat_t   rstat;
    sm3_pkg::sm3_words_t      work;
    logic                     start;
    logic [31:0]              w0, w4;
    logic [5:0]               n;

    assign n = count_reg[8:3];

    sm3_msg_sched u_sched (
        .clk  (clk),
        .ctrl (sctrl),
        .w0   (w0),
        .w4   (w4)
    );

    sm3_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .v_in  (cv_reg),
        .w0    (w0),
        .w4    (w4),
        .work  (work),
        .stat  (rstat)
    );

    assign in_ready              = (state_reg == S_IDLE);
    assign out_valid             = (state_reg == S_OUT);
    assign out_data.digest_word  = cv_reg[word_idx_reg];
    assign out_data.word_index   = word_idx_reg;
    assign out_data.last_word    = (word_idx_reg == 3'd7);

    always_comb
    begin
        state_next    = state_reg;
        pend_end_next = pend_end_reg;
        fin_next      = fin_reg;
        extra_next    = extra_reg;
        word_idx_next = word_idx_reg;
        count_next    = count_reg;
        cv_next       = cv_reg;
        start         = 1'b0;

        sctrl         = '0;
        sctrl.wr_addr = n;
        sctrl.wr_data = in_data.data_byte;
        sctrl.pad_n   = n;
        sctrl.length  = count_reg;
        sctrl.shift   = rstat.busy;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.byte_present)
                    begin
                        sctrl.wr_en = 1'b1;
                        count_next  = count_reg + 64'd8;
                        if (n == sm3_pkg::SM3_LAST_POS)
                        begin
                            start         = 1'b1;
                            pend_end_next = in_data.end_of_message;
                            state_next    = S_COMP;
                        end
                        else if (in_data.end_of_message)
                            state_next = S_PAD;
                    end
                    else if (in_data.end_of_message)
                        state_next = S_PAD;
                end
            end
            S_COMP:
            begin
                if (rstat.done)
                begin
                    cv_next    = cv_reg ^ work;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (extra_reg || pend_end_reg)
                    state_next = S_PAD;
                else if (fin_reg)
                begin
                    word_idx_next = '0;
                    state_next    = S_OUT;
                end
                else
                    state_next = S_IDLE;
            end
            S_PAD:
            begin
                sctrl.load = 1'b1;
                start      = 1'b1;
                state_next = S_COMP;
                if (extra_reg)
                begin
                    // Length-only block after an overflowing pad
                    sctrl.len_en = 1'b1;
                    extra_next   = 1'b0;
                end
                else
                begin
                    sctrl.mark    = 1'b1;
                    sctrl.len_en  = (n < sm3_pkg::SM3_LEN_POS);
                    extra_next    = (n >= sm3_pkg::SM3_LEN_POS);
                    pend_end_next = 1'b0;
                    fin_next      = 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    word_idx_next = word_idx_reg + 3'd1;
                    if (word_idx_reg == 3'd7)
                    begin
                        cv_next    = sm3_pkg::SM3_IV;
                        count_next = '0;
                        fin_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_end_reg <= 1'b0;
            fin_reg      <= 1'b0;
            extra_reg    <= 1'b0;
            word_idx_reg <= '0;
            count_reg    <= '0;
            cv_reg       <= sm3_pkg::SM3_IV;
        end
        else
        begin
            state_reg    <= state_next;
            pend_end_reg <= pend_end_next;
            fin_reg      <= fin_next;
            extra_reg    <= extra_next;
            word_idx_reg <= word_idx_next;
            count_reg    <= count_next;
            cv_reg       <= cv_next;
        end
    end

    a_busy_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        rstat.busy |-> (state_reg == S_COMP))
        else $error("round unit busy outside compression state");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while digest is being emitted");

    a_done_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP && rstat.done) |=> (state_reg == S_NEXT))
        else $error("compression done not merged");

    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last_word) |=>
            (count_reg == 64'd0 && cv_reg == sm3_pkg::SM3_IV))
        else $error("state not restored after digest");

    a_extra_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        extra_reg |-> fin_reg)
        else $error("extra pad block outside final padding");

endmodule

`default_nettype wire

// ===== hdl/sm3_msg_sched.sv =====
// SM3 message schedule: 16-word window that doubles as the block buffer.
// Takes byte writes, padded block loads, and shifts one word per round.
// Depends on sm3_pkg.
`default_nettype none

module sm3_msg_sched (
    input  wire logic                     clk,
    input  wire sm3_pkg::sm3_sched_ctrl_t ctrl,
    output logic [31:0]                   w0,
    output logic [31:0]                   w4
);

    logic [31:0] win_reg [0:15];
    logic [31:0] pad_word [0:15];
    logic [31:0] w_new;
    logic [5:0]  pos;
    logic [7:0]  byte_val;

    assign w0 = win_reg[0];
    assign w4 = win_reg[4];

    assign w_new = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl(win_reg[13], 5'd15))
                 ^ sm3_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];

    // If mark, bytes below pad_n kept, 0x80 at pad_n; rest zero; length if len_en
    always_comb
    begin
        pos      = '0;
        byte_val = '0;
        for (int i = 0; i < 16; i++)
        begin
            for (int b = 0; b < 4; b++)
            begin
                pos = 6'(4 * i + b);
                if (ctrl.mark && (pos < ctrl.pad_n))
                    byte_val = win_reg[i][8 * (3 - b) +: 8];
                else if (ctrl.mark && (pos == ctrl.pad_n))
                    byte_val = sm3_pkg::SM3_PAD_BYTE;
                else
                    byte_val = '0;
                pad_word[i][8 * (3 - b) +: 8] = byte_val;
            end
        end
        if (ctrl.len_en)
        begin
            pad_word[14] = ctrl.length[63:32];
            pad_word[15] = ctrl.length[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < 16; i++)
                win_reg[i] <= pad_word[i];
        end
        else if (ctrl.wr_en)
        begin
            win_reg[ctrl.wr_addr[5:2]][{~ctrl.wr_addr[1:0], 3'b000} +: 8] <= ctrl.wr_data;
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= w_new;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sm3_round.sv =====
// SM3 compression round unit: eight working words, one round per cycle,
// 64 rounds per block under its own round counter. Depends on sm3_pkg.
`default_nettype none

module sm3_round (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire sm3_pkg::sm3_words_t   v_in,
    input  wire logic [31:0]           w0,
    input  wire logic [31:0]           w4,
    output sm3_pkg::sm3_words_t        work,
    output sm3_pkg::sm3_rnd_stat_t     stat
);

    sm3_pkg::sm3_words_t work_reg, work_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;

    assign work      = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_comb
    begin
        a12 = sm3_pkg::rotl(work_reg[0], 5'd12);
        ss1 = sm3_pkg::rotl(a12 + work_reg[4] + sm3_pkg::tj_rot(cnt_reg), 5'd7);
        ss2 = ss1 ^ a12;
        if (cnt_reg < 6'd16)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
               | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ff + work_reg[3] + ss2 + (w0 ^ w4);
        tt2 = gg + work_reg[7] + ss1 + w0;

        work_next = work_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            work_next = v_in;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next[3] = work_reg[2];
            work_next[2] = sm3_pkg::rotl(work_reg[1], 5'd9);
            work_next[1] = work_reg[0];
            work_next[0] = tt1;
            work_next[7] = work_reg[6];
            work_next[6] = sm3_pkg::rotl(work_reg[5], 5'd19);
            work_next[5] = work_reg[4];
            work_next[4] = sm3_pkg::perm0(tt2);
            cnt_next     = cnt_reg + 6'd1;
            if (cnt_reg == sm3_pkg::SM3_LAST_RND)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_sm3_hash_engine.sv =====
// Self-checking testbench for sm3_hash_engine: byte stream in, digest words out.
// Needs sm3_pkg (port payload types) and the engine RTL; predicts SM3 digests locally.
`timescale 1ns / 1ps

module tb_sm3_hash_engine;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 60;
    localparam int REPORT_LIMIT = 10;

    localparam logic [7:0][31:0] CV_INIT = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int         LEN_SLOT = 56;

    typedef enum int {PH_FULL, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_mode_t;

    typedef struct {
        sm3_pkg::sm3_in_t beat;
        idle_mode_t       mode;
        bit               drain;
        bit               hold;
    } feed_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    sm3_pkg::sm3_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    sm3_pkg::sm3_out_t out_data;

    sm3_hash_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor state
    logic [7:0][31:0] cv_state  = CV_INIT;
    logic [511:0]     msg_block = '0;
    logic [63:0]      bit_total = '0;

    feed_t             feed_q[$];
    sm3_pkg::sm3_out_t digest_q[$];
    int                fail_count = 0;
    int                item_total = 0;
    int                quiet_cycles = 0;
    idle_mode_t        rx_mode = PH_FULL;
    int                hold_req = 0;

    // Generator controls, applied to the next pushed beat
    idle_mode_t gen_mode  = PH_FULL;
    bit         gen_hold  = 1'b0;
    bit         gen_drain = 1'b0;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] mix0(input logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] mix1(input logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    // One SM3 compression of a 512-bit block, byte 0 in the top bits
    function automatic logic [7:0][31:0] sm3_fold(input logic [7:0][31:0] cv,
                                                  input logic [511:0] blk);
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tj, ss1, ss2, ff, gg, tt1, tt2;
        logic [7:0][31:0] res;
        int j;
        for (j = 0; j < 16; j++)
            w[j] = blk[511 - 32 * j -: 32];
        for (j = 16; j < 68; j++)
            w[j] = mix1(w[j - 16] ^ w[j - 9] ^ rol32(w[j - 3], 15)) ^
                   rol32(w[j - 13], 7) ^ w[j - 6];
        a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
        e = cv[4]; f = cv[5]; g = cv[6]; h = cv[7];
        for (j = 0; j < 64; j++)
        begin
            tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
            ss1 = rol32(rol32(a, 12) + e + rol32(tj, j % 32), 7);
            ss2 = ss1 ^ rol32(a, 12);
            if (j < 16)
            begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end
            else
            begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j + 4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol32(b, 9); b = a; a = tt1;
            h = g; g = rol32(f, 19); f = e; e = mix0(tt2);
        end
        res[0] = cv[0] ^ a; res[1] = cv[1] ^ b; res[2] = cv[2] ^ c; res[3] = cv[3] ^ d;
        res[4] = cv[4] ^ e; res[5] = cv[5] ^ f; res[6] = cv[6] ^ g; res[7] = cv[7] ^ h;
        return res;
    endfunction

    // Absorb one accepted beat; queue the digest words on end of message
    task automatic hash_absorb(input sm3_pkg::sm3_in_t beat);
        logic [5:0]        n;
        logic [7:0][31:0]  tv;
        logic [511:0]      tb;
        sm3_pkg::sm3_out_t word;
        int                k;
        if (beat.byte_present)
        begin
            n = bit_total[8:3];
            msg_block[511 - 8 * n -: 8] = beat.data_byte;
            bit_total = bit_total + 64'd8;
            if (n == 6'd63)
                cv_state = sm3_fold(cv_state, msg_block);
        end
        if (beat.end_of_message)
        begin
            n  = bit_total[8:3];
            tv = cv_state;
            // keep only the bytes of the current block
            tb = msg_block & ~({512{1'b1}} >> (8 * n));
            tb[511 - 8 * n -: 8] = PAD_MARK;
            if (n >= LEN_SLOT)
            begin
                tv = sm3_fold(tv, tb);
                tb = '0;
            end
            tb[63:0] = bit_total;
            tv = sm3_fold(tv, tb);
            for (k = 0; k < 8; k++)
            begin
                word.digest_word = tv[k];
                word.word_index  = 3'(k);
                word.last_word   = (k == 7);
                digest_q.push_back(word);
            end
            cv_state  = CV_INIT;
            bit_total = '0;
        end
    endtask

    function automatic int idle_pct(input idle_mode_t mode, input bit sink_side);
        case (mode)
            PH_SRC_IDLE:  return sink_side ? 0 : 51;
            PH_SNK_STALL: return sink_side ? 51 : 0;
            PH_BOTH:      return 37;
            default:      return 0;
        endcase
    endfunction

    task automatic push_beat(input logic [7:0] data, input bit present, input bit eom);
        feed_t f;
        f.beat.data_byte      = data;
        f.beat.byte_present   = present;
        f.beat.end_of_message = eom;
        f.mode  = gen_mode;
        f.drain = gen_drain;
        f.hold  = gen_hold;
        gen_drain = 1'b0;
        gen_hold  = 1'b0;
        feed_q.push_back(f);
        item_total++;
    endtask

    task automatic push_message(input int len);
        bit tail_on_byte;
        int i;
        tail_on_byte = (len != 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            // sprinkle empty steps
            if ($urandom_range(19) == 0)
                push_beat(8'($urandom), 1'b0, 1'b0);
            push_beat(8'($urandom), 1'b1, tail_on_byte && (i == len - 1));
        end
        if (!tail_on_byte)
            push_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(12);
        if (r < 70)
            return $urandom_range(40, 13);
        if (r < 85)
        begin
            // padding and block boundaries
            case ($urandom_range(7))
                0:       return 55;
                1:       return 56;
                2:       return 57;
                3:       return 63;
                4:       return 64;
                5:       return 65;
                6:       return 119;
                default: return 120;
            endcase
        end
        return $urandom_range(140, 41);
    endfunction

    // Driver
    logic  offering;
    feed_t head;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            offering = in_valid;
            if (in_valid && in_ready)
            begin
                hash_absorb(in_data);
                offering = 1'b0;
            end
            if (!offering && feed_q.size() != 0)
            begin
                head = feed_q[0];
                // hold a drain beat back until all digests are out
                if (!(head.drain && digest_q.size() != 0) &&
                    $urandom_range(99) >= idle_pct(head.mode, 1'b0))
                begin
                    void'(feed_q.pop_front());
                    in_data <= head.beat;
                    rx_mode <= head.mode;
                    if (head.hold)
                        hold_req <= hold_req + 1;
                    offering = 1'b1;
                end
            end
            in_valid <= offering;
        end
    end

    // Receiver ready
    int hold_left;
    int hold_seen;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end
        else
        begin
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= idle_pct(rx_mode, 1'b1));
        end
    end

    // Monitor and watchdog
    sm3_pkg::sm3_out_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected digest beat: word %08h idx %0d last %0b",
                             out_data.digest_word, out_data.word_index, out_data.last_word);
            end
            else
            begin
                want = digest_q.pop_front();
                if (out_data.digest_word !== want.digest_word ||
                    out_data.word_index !== want.word_index ||
                    out_data.last_word !== want.last_word)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("digest mismatch: want %08h/%0d/%0b got %08h/%0d/%0b",
                                 want.digest_word, want.word_index, want.last_word,
                                 out_data.digest_word, out_data.word_index,
                                 out_data.last_word);
                end
            end
        end
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    int m;
    int phase_start;
    int msg_no;

    initial
    begin
        // Directed: empty step, empty message, "abc", byte extremes
        push_beat(8'hFF, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1);
        push_beat(8'h61, 1'b1, 1'b0);
        push_beat(8'h62, 1'b1, 1'b0);
        push_beat(8'h63, 1'b1, 1'b1);
        push_beat(8'h00, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b0);
        push_beat(8'hA5, 1'b0, 1'b0);
        push_beat(8'h5A, 1'b0, 1'b1);
        push_beat(8'hFF, 1'b1, 1'b1);

        for (m = 0; m < 4; m++)
        begin
            gen_mode    = idle_mode_t'(m);
            phase_start = item_total;
            msg_no      = 0;
            while (item_total - phase_start < PHASE_ITEMS)
            begin
                if (gen_mode == PH_FULL && msg_no == 1)
                    gen_hold = 1'b1;
                if (gen_mode == PH_BOTH && msg_no == 2)
                    gen_drain = 1'b1;
                push_message(pick_len());
                msg_no++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || in_valid)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sm3_pkg.sv
hdl/sm3_msg_sched.sv
hdl/sm3_round.sv
hdl/sm3_hash_engine.sv
dv/tb_sm3_hash_engine.sv
